@@ rtl/lbmc_pkg.sv @@
// Shared types, constants and arithmetic helpers for the D2Q9 cell collision pipeline.
package lbmc_pkg;

  // Q4.28 signed word.
  typedef logic signed [31:0] q28_t;

  localparam int NDIR = 9;
  localparam int FRAC = 28;

  // Direction slots in the order of the data words.
  localparam int DR  = 0;
  localparam int DE  = 1;
  localparam int DNE = 2;
  localparam int DSE = 3;
  localparam int DW  = 4;
  localparam int DNW = 5;
  localparam int DSW = 6;
  localparam int DN  = 7;
  localparam int DS  = 8;

  localparam logic signed [39:0] ONE_Q = 40'sd268435456;
  localparam logic signed [39:0] TWO_Q = 40'sd536870912;
  localparam logic [30:0] SPEED_MAX = 31'h7FFF_FFFF;
  localparam logic [29:0] RELAX_RESET = 30'd496605594;

  // Equilibrium weights (already halved) per direction.
  localparam logic signed [32:0] WGT [0:8] = '{
    33'sd59652324, 33'sd14913081, 33'sd3728270, 33'sd3728270, 33'sd14913081,
    33'sd3728270, 33'sd3728270, 33'sd14913081, 33'sd14913081};

  // Opposite direction, used for bounce-back.
  localparam logic [3:0] OPP [0:8] = '{
    4'd0, 4'd4, 4'd6, 4'd5, 4'd1, 4'd3, 4'd2, 4'd8, 4'd7};

  // Restoring divider and square root: four steps per pipeline stage.
  localparam int DIV_STEPS  = 4;
  localparam int DIV_STAGES = 32 / DIV_STEPS;
  localparam int RT_STEPS   = 4;
  localparam int RT_STAGES  = 32 / RT_STEPS;

  // Pipeline stage numbers.
  localparam int S_IN   = 1;
  localparam int S_DIV0 = 2;
  localparam int S_DIVL = S_DIV0 + DIV_STAGES - 1;
  localparam int S_U    = S_DIVL + 1;
  localparam int S_SQ   = S_U + 1;
  localparam int S_TERM = S_SQ + 1;
  localparam int S_TT   = S_TERM + 1;
  localparam int S_FEQ  = S_TT + 1;
  localparam int S_TGT  = S_FEQ + 1;
  localparam int S_REL  = S_TGT + 1;
  localparam int S_NEW  = S_REL + 1;
  localparam int S_MOM  = S_NEW + 1;
  localparam int S_SQR  = S_MOM + 1;
  localparam int S_RT0  = S_SQR + 1;
  localparam int S_RTL  = S_RT0 + RT_STAGES - 1;
  localparam int S_SD0  = S_RTL + 1;
  localparam int S_SDL  = S_SD0 + DIV_STAGES - 1;
  localparam int NS     = S_SDL + 1;

  typedef struct packed {
    logic obst;
    q28_t [8:0] f;
    q28_t rho;
  } pass_t;

  typedef struct packed {
    logic obst;
    q28_t [8:0] q;
  } cell_t;

  typedef struct packed {
    logic [35:0] rem;
    logic [31:0] qw;
  } dstate_t;

  typedef struct packed {
    dstate_t s;
    logic neg;
    logic ovf;
    logic zero;
  } dlane_t;

  typedef struct packed {
    dstate_t s;
    logic ovf;
    logic nz;
  } spd_t;

  typedef struct packed {
    logic [33:0] rem;
    logic [31:0] root;
    logic [63:0] vw;
  } rstate_t;

  // Clamp to the signed 32-bit range.
  function automatic q28_t sat32(input logic signed [39:0] v);
    if (v > 40'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -40'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  // Q.28 product, rounded toward minus infinity.
  function automatic logic signed [37:0] mq(input logic signed [32:0] a,
                                            input logic signed [32:0] b);
    logic signed [65:0] p;
    p = a * b;
    return p[65:28];
  endfunction

  // Divisor magnitude of a signed word; zero turns into one.
  function automatic logic [35:0] den_mag(input q28_t den);
    logic [31:0] m;
    m = den[31] ? 32'(-den) : 32'(den);
    return (den == '0) ? 36'd1 : {4'b0000, m};
  endfunction

  // One restoring division step.
  function automatic dstate_t div_step(input dstate_t s, input logic [35:0] d);
    dstate_t o;
    logic [36:0] t;
    t = {s.rem, s.qw[31]};
    if (t >= {1'b0, d}) begin
      o.rem = 36'(t - {1'b0, d});
      o.qw  = {s.qw[30:0], 1'b1};
    end else begin
      o.rem = t[35:0];
      o.qw  = {s.qw[30:0], 1'b0};
    end
    return o;
  endfunction

  function automatic dstate_t div_steps(input dstate_t s, input logic [35:0] d);
    dstate_t o;
    o = s;
    for (int i = 0; i < DIV_STEPS; i++) o = div_step(o, d);
    return o;
  endfunction

  // Set up (num << 28) / den; ovf marks a quotient of 2^32 or more.
  function automatic dlane_t div_init(input logic signed [34:0] num, input q28_t den);
    dlane_t l;
    logic [33:0] mag;
    logic [35:0] d;
    mag = num[34] ? 34'(-num) : 34'(num);
    d = den_mag(den);
    l.zero = (den == '0);
    l.neg = num[34] ^ den[31];
    l.ovf = (36'(mag[33:4]) >= d);
    l.s.rem = l.ovf ? '0 : 36'(mag[33:4]);
    l.s.qw = {mag[3:0], 28'd0};
    return l;
  endfunction

  // Signed, saturated quotient.
  function automatic q28_t div_fin(input dlane_t l);
    if (l.zero) return '0;
    if (l.neg) begin
      if (l.ovf || (l.s.qw > 32'h8000_0000)) return 32'sh8000_0000;
      return q28_t'(-l.s.qw);
    end
    if (l.ovf || l.s.qw[31]) return 32'sh7FFF_FFFF;
    return q28_t'(l.s.qw);
  endfunction

  // One step of the digit-by-digit integer square root.
  function automatic rstate_t sqrt_step(input rstate_t s);
    rstate_t o;
    logic [35:0] cur;
    logic [35:0] trial;
    cur = {s.rem, s.vw[63:62]};
    trial = {2'b00, s.root, 2'b01};
    o.vw = {s.vw[61:0], 2'b00};
    if (cur >= trial) begin
      o.rem = 34'(cur - trial);
      o.root = {s.root[30:0], 1'b1};
    end else begin
      o.rem = cur[33:0];
      o.root = {s.root[30:0], 1'b0};
    end
    return o;
  endfunction

  function automatic rstate_t sqrt_steps(input rstate_t s);
    rstate_t o;
    o = s;
    for (int i = 0; i < RT_STEPS; i++) o = sqrt_step(o);
    return o;
  endfunction

endpackage

@@ rtl/lbm_d2q9_cell_collision_top.sv @@
// D2Q9 BGK collision for one lattice cell per cycle when not stalled, as a deep valid/ready pipeline.
//
// Channel | Direction | Handshake          | Content
// in_     | slave     | in_tvalid/tready   | nine densities (tdata), obstacle flag (tuser)
// out_    | master    | out_tvalid/tready  | nine new densities and speed_part (tdata)
// cfg_    | slave     | cfg_valid/ready    | relax_rate, Q2.28 (cfg_data)
//
// One item enters per cycle while the pipeline is not stalled.
// Most of the pipeline depth comes from the two pipelined restoring dividers and the square root stages,
// four quotient or root bits per stage.
// Reset clears the valid bits and loads relax_rate with its default; no clearing pass.
// Each stage holds its item while the next stage is full and stalled, so a stall loses
// nothing and empty stages keep filling while the output waits.
module lbm_d2q9_cell_collision_top
  import lbmc_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // rest_in, east_in, north_east_in, south_east_in, west_in, north_west_in,
  // south_west_in, north_in, south_in (32 bits each, from bit 0 up)
  input  logic [287:0] in_tdata,
  // obstacle
  input  logic         in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // rest_out, east_out, north_east_out, south_east_out, west_out, north_west_out,
  // south_west_out, north_out, south_out (32 bits each), speed_part (31 bits), one zero bit
  output logic [319:0] out_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [29:0]  cfg_data
);

  // Relaxation rate register.
  logic [29:0] relax_rate_r;
  logic signed [32:0] om;

  assign cfg_ready = 1'b1;
  assign om = $signed(33'({3'b000, relax_rate_r}));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      relax_rate_r <= RELAX_RESET;
    end else if (cfg_valid) begin
      relax_rate_r <= cfg_data;
    end
  end

  // Stage handshake: a stage loads when it is empty or its item moves on.
  logic [1:NS]   v_r;
  logic [1:NS+1] acc;

  always_comb begin
    acc[NS+1] = out_tready;
    for (int k = NS; k >= 1; k--) acc[k] = ~v_r[k] | acc[k+1];
  end

  assign in_tready = acc[1];
  assign out_tvalid = v_r[NS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (acc[1]) v_r[1] <= in_tvalid;
      for (int k = 2; k <= NS; k++) begin
        if (acc[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  // Stage 1: unpack, density and momentum sums.
  pass_t pt_r [S_IN:S_REL];
  pass_t in_pt;
  logic signed [39:0] rho_sum, mx_sum, my_sum;
  logic signed [34:0] mx_r, my_r;

  always_comb begin
    in_pt.obst = in_tuser;
    for (int i = 0; i < NDIR; i++) in_pt.f[i] = in_tdata[32*i +: 32];
    rho_sum = '0;
    for (int i = 0; i < NDIR; i++) rho_sum = rho_sum + 40'($signed(in_pt.f[i]));
    in_pt.rho = sat32(rho_sum);
    mx_sum = 40'($signed(in_pt.f[DE])) + 40'($signed(in_pt.f[DNE]))
           + 40'($signed(in_pt.f[DSE])) - 40'($signed(in_pt.f[DW]))
           - 40'($signed(in_pt.f[DNW])) - 40'($signed(in_pt.f[DSW]));
    my_sum = 40'($signed(in_pt.f[DN])) + 40'($signed(in_pt.f[DNE]))
           + 40'($signed(in_pt.f[DNW])) - 40'($signed(in_pt.f[DS]))
           - 40'($signed(in_pt.f[DSW])) - 40'($signed(in_pt.f[DSE]));
  end

  always_ff @(posedge clk) begin
    if (acc[S_IN]) begin
      pt_r[S_IN] <= in_pt;
      mx_r <= 35'(mx_sum);
      my_r <= 35'(my_sum);
    end
  end

  // Pass the cell inputs along until the new densities are formed.
  for (genvar k = S_IN + 1; k <= S_REL; k++) begin : g_pass
    always_ff @(posedge clk) begin
      if (acc[k]) pt_r[k] <= pt_r[k-1];
    end
  end

  // Velocity dividers: ux = mx / rho and uy = my / rho.
  dlane_t dx_r [S_DIV0:S_DIVL];
  dlane_t dy_r [S_DIV0:S_DIVL];

  for (genvar k = S_DIV0; k <= S_DIVL; k++) begin : g_div
    dlane_t x_in, y_in, x_nxt, y_nxt;
    logic [35:0] d;
    if (k == S_DIV0) begin : g_first
      assign x_in = div_init(mx_r, pt_r[k-1].rho);
      assign y_in = div_init(my_r, pt_r[k-1].rho);
    end else begin : g_next
      assign x_in = dx_r[k-1];
      assign y_in = dy_r[k-1];
    end
    always_comb begin
      d = den_mag(pt_r[k-1].rho);
      x_nxt = x_in;
      y_nxt = y_in;
      x_nxt.s = div_steps(x_in.s, d);
      y_nxt.s = div_steps(y_in.s, d);
    end
    always_ff @(posedge clk) begin
      if (acc[k]) begin
        dx_r[k] <= x_nxt;
        dy_r[k] <= y_nxt;
      end
    end
  end

  // Velocity, its squares, the shifted terms and the equilibrium chain.
  q28_t ux_r, uy_r, ex_r, ey_r, b_r, b2_r;
  logic signed [37:0] uxx_r, uyy_r;
  q28_t term_r [0:8];
  logic signed [37:0] tt_r [0:8];
  q28_t feq_r [0:8];
  q28_t tgt_r [0:8];
  logic signed [37:0] rel_r [0:8];
  q28_t u2, b_nxt, ne, nw;
  q28_t term_nxt [0:8];

  always_comb begin
    u2 = sat32(40'(uxx_r) + 40'(uyy_r));
    b_nxt = sat32(ONE_Q - 40'(u2) - (40'(u2) <<< 1));
    ne = sat32(40'(ex_r) + 40'(ey_r) - ONE_Q);
    nw = sat32(40'(ey_r) - 40'(ex_r) + ONE_Q);
    term_nxt[DR]  = q28_t'(ONE_Q);
    term_nxt[DE]  = ex_r;
    term_nxt[DN]  = ey_r;
    term_nxt[DW]  = sat32(TWO_Q - 40'(ex_r));
    term_nxt[DS]  = sat32(TWO_Q - 40'(ey_r));
    term_nxt[DNE] = ne;
    term_nxt[DNW] = nw;
    term_nxt[DSW] = sat32(TWO_Q - 40'(ne));
    term_nxt[DSE] = sat32(TWO_Q - 40'(nw));
  end

  always_ff @(posedge clk) begin
    if (acc[S_U]) begin
      ux_r <= div_fin(dx_r[S_DIVL]);
      uy_r <= div_fin(dy_r[S_DIVL]);
    end
    if (acc[S_SQ]) begin
      uxx_r <= mq(33'(ux_r), 33'(ux_r));
      uyy_r <= mq(33'(uy_r), 33'(uy_r));
      ex_r <= sat32(40'(ux_r) + (40'(ux_r) <<< 1) + ONE_Q);
      ey_r <= sat32(40'(uy_r) + (40'(uy_r) <<< 1) + ONE_Q);
    end
    if (acc[S_TERM]) begin
      b_r <= b_nxt;
      for (int i = 0; i < NDIR; i++) term_r[i] <= term_nxt[i];
    end
    if (acc[S_TT]) begin
      b2_r <= b_r;
      for (int i = 0; i < NDIR; i++) tt_r[i] <= mq(33'(term_r[i]), 33'(term_r[i]));
    end
    if (acc[S_FEQ]) begin
      for (int i = 0; i < NDIR; i++) begin
        feq_r[i] <= sat32(40'(mq(33'(sat32(40'(tt_r[i]) + 40'(b2_r))), WGT[i])));
      end
    end
    if (acc[S_TGT]) begin
      for (int i = 0; i < NDIR; i++) begin
        tgt_r[i] <= sat32(40'(mq(33'(feq_r[i]), 33'($signed(pt_r[S_FEQ].rho)))));
      end
    end
    if (acc[S_REL]) begin
      for (int i = 0; i < NDIR; i++) begin
        rel_r[i] <= mq(om, 33'(tgt_r[i]) - 33'($signed(pt_r[S_TGT].f[i])));
      end
    end
  end

  // New densities: relaxed, or swapped for a blocked cell.
  cell_t qc_r [S_NEW:NS];
  cell_t new_cell;

  always_comb begin
    new_cell.obst = pt_r[S_REL].obst;
    for (int i = 0; i < NDIR; i++) begin
      if (pt_r[S_REL].obst) begin
        new_cell.q[i] = pt_r[S_REL].f[OPP[i]];
      end else begin
        new_cell.q[i] = sat32(40'($signed(pt_r[S_REL].f[i])) + 40'(rel_r[i]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc[S_NEW]) qc_r[S_NEW] <= new_cell;
  end

  for (genvar k = S_NEW + 1; k <= NS; k++) begin : g_cell
    always_ff @(posedge clk) begin
      if (acc[k]) qc_r[k] <= qc_r[k-1];
    end
  end

  // New density sum and momentum magnitudes.
  logic signed [35:0] r2_r [S_MOM:S_SDL];
  logic signed [39:0] rho2_sum, nx_sum, ny_sum;
  q28_t nx, ny;
  logic [31:0] ax_r, ay_r;
  logic [63:0] sx_r, sy_r;

  always_comb begin
    rho2_sum = '0;
    for (int i = 0; i < NDIR; i++) rho2_sum = rho2_sum + 40'($signed(qc_r[S_NEW].q[i]));
    nx_sum = 40'($signed(qc_r[S_NEW].q[DE])) + 40'($signed(qc_r[S_NEW].q[DNE]))
           + 40'($signed(qc_r[S_NEW].q[DSE])) - 40'($signed(qc_r[S_NEW].q[DW]))
           - 40'($signed(qc_r[S_NEW].q[DNW])) - 40'($signed(qc_r[S_NEW].q[DSW]));
    ny_sum = 40'($signed(qc_r[S_NEW].q[DN])) + 40'($signed(qc_r[S_NEW].q[DNE]))
           + 40'($signed(qc_r[S_NEW].q[DNW])) - 40'($signed(qc_r[S_NEW].q[DS]))
           - 40'($signed(qc_r[S_NEW].q[DSW])) - 40'($signed(qc_r[S_NEW].q[DSE]));
    nx = sat32(nx_sum);
    ny = sat32(ny_sum);
  end

  always_ff @(posedge clk) begin
    if (acc[S_MOM]) begin
      r2_r[S_MOM] <= 36'(rho2_sum);
      ax_r <= nx[31] ? 32'(-nx) : 32'(nx);
      ay_r <= ny[31] ? 32'(-ny) : 32'(ny);
    end
    if (acc[S_SQR]) begin
      sx_r <= ax_r * ax_r;
      sy_r <= ay_r * ay_r;
    end
  end

  for (genvar k = S_MOM + 1; k <= S_SDL; k++) begin : g_rho2
    always_ff @(posedge clk) begin
      if (acc[k]) r2_r[k] <= r2_r[k-1];
    end
  end

  // Square root of the squared momentum norm.
  rstate_t rt_r [S_RT0:S_RTL];

  for (genvar k = S_RT0; k <= S_RTL; k++) begin : g_root
    rstate_t r_in;
    if (k == S_RT0) begin : g_first
      always_comb begin
        r_in.rem = '0;
        r_in.root = '0;
        r_in.vw = sx_r + sy_r;
      end
    end else begin : g_next
      assign r_in = rt_r[k-1];
    end
    always_ff @(posedge clk) begin
      if (acc[k]) rt_r[k] <= sqrt_steps(r_in);
    end
  end

  // Speed divider: (norm << 28) / rho2, divisor forced to one when rho2 is not positive.
  spd_t sd_r [S_SD0:S_SDL];

  for (genvar k = S_SD0; k <= S_SDL; k++) begin : g_sdiv
    spd_t s_in, s_nxt;
    logic [35:0] d;
    if (k == S_SD0) begin : g_first
      always_comb begin
        s_in.nz = (rt_r[S_RTL].root != '0);
        s_in.ovf = (36'(rt_r[S_RTL].root[31:4]) >= d);
        s_in.s.rem = s_in.ovf ? '0 : 36'(rt_r[S_RTL].root[31:4]);
        s_in.s.qw = {rt_r[S_RTL].root[3:0], 28'd0};
      end
    end else begin : g_next
      assign s_in = sd_r[k-1];
    end
    always_comb begin
      d = (r2_r[k-1] > 36'sd0) ? 36'(r2_r[k-1]) : 36'd1;
      s_nxt = s_in;
      s_nxt.s = div_steps(s_in.s, d);
    end
    always_ff @(posedge clk) begin
      if (acc[k]) sd_r[k] <= s_nxt;
    end
  end

  // Output stage: speed clamp and special cases.
  logic [30:0] speed_r, speed_nxt;

  always_comb begin
    if (qc_r[S_SDL].obst) begin
      speed_nxt = '0;
    end else if (r2_r[S_SDL] == '0) begin
      speed_nxt = sd_r[S_SDL].nz ? SPEED_MAX : '0;
    end else if (r2_r[S_SDL][35]) begin
      speed_nxt = '0;
    end else if (sd_r[S_SDL].ovf || sd_r[S_SDL].s.qw[31]) begin
      speed_nxt = SPEED_MAX;
    end else begin
      speed_nxt = sd_r[S_SDL].s.qw[30:0];
    end
  end

  always_ff @(posedge clk) begin
    if (acc[NS]) speed_r <= speed_nxt;
  end

  always_comb begin
    out_tdata = '0;
    for (int i = 0; i < NDIR; i++) out_tdata[32*i +: 32] = qc_r[NS].q[i];
    out_tdata[318:288] = speed_r;
  end

endmodule

@@ rtl/lbmc_checker.sv @@
// Port-level checks for the collision pipeline, bound to the top level.
module lbmc_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [319:0] out_tdata
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("output item dropped while stalled");

  // A stalled result keeps its data.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("output item changed while stalled");

  // With the output side ready, the whole pipeline moves and takes input.
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("input stalled although the output is ready");

  // Reset empties the pipeline.
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

endmodule

bind lbm_d2q9_cell_collision_top lbmc_checker u_lbmc_checker (.*);
